FILE: src/assert_macros.svh
// Assertion macros used by the block pool allocator top level.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_AT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/bpa_pkg.sv
// Shared types and constants for the block pool allocator.
// No dependencies.
`default_nettype none

package bpa_pkg;

  // Index space is fixed by the 10-bit block index.
  localparam int unsigned IdxW      = 10;
  localparam int unsigned MaxBlocks = 1 << IdxW;
  localparam int unsigned CntW      = IdxW + 1;
  localparam int unsigned BppW      = 7;

  localparam logic [BppW-1:0] BppReset = 7'd64;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_DOUBLE  = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

endpackage

`default_nettype wire

FILE: src/bpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // Hold read data until the next read.
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: src/block_pool_allocator.sv
// Block pool allocator: top level.
// Depends on bpa_pkg, bpa_ram and assert_macros.svh.
//
// Hands out and takes back fixed-size block indices (0..1023). Each request is
// an allocate or a free and produces exactly one response with a granted index
// and a status (ok, out of memory, double free, invalid index). Fresh blocks of
// the newest pool are served in ascending order; after that, freed blocks are
// served in the order they were freed, from a FIFO held in a 1024-entry RAM.
// When nothing is left, a new pool of blocks_per_pool indices is added, up to
// MAX_POOLS pools or 1024 blocks, after which allocation reports out of memory.
// A request passes the idle state, which presents the RAM reads (free-list
// head and in-use flag), then the execute state, which read-modify-writes the
// flag and queue RAMs and loads the response register; no new request is
// taken before it is done. Execute waits while the response register holds
// a result that has not been taken. No clearing pass runs after reset: an
// in-use flag is trusted only for indices below the fresh-block pointer, which
// have all been written, so requests are accepted from the first cycle.
// blocks_per_pool is written through cfg_we_i/cfg_wdata_i while the block is
// idle; while no block has been handed out it also resizes the first pool.
`default_nettype none

`include "assert_macros.svh"

module block_pool_allocator #(
  parameter int unsigned MAX_POOLS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [bpa_pkg::BppW-1:0]      cfg_wdata_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [bpa_pkg::IdxW-1:0]      block_index_i,
  // response channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bpa_pkg::IdxW-1:0]      granted_index_o,
  output logic [1:0]                    status_o
);

  import bpa_pkg::*;

  localparam int unsigned PoolW = $clog2(MAX_POOLS + 1);

  localparam logic SIdle = 1'b0;
  localparam logic SExec = 1'b1;

  // Control state
  logic            state_q, state_d;
  logic [BppW-1:0] bpp_q, bpp_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [PoolW-1:0] pools_q, pools_d;
  logic [CntW-1:0] fresh_next_q, fresh_next_d;
  logic [CntW-1:0] fresh_limit_q, fresh_limit_d;
  logic            out_valid_q, out_valid_d;

  // Request and response payload
  logic            cmd_q;
  logic [IdxW-1:0] idx_q;
  logic [IdxW-1:0] granted_q, granted_d;
  status_e         status_q, status_d;

  // RAM ports
  logic            flag_we;
  logic [IdxW-1:0] flag_waddr;
  logic            flag_wdata;
  logic            flag_rdata;
  logic            queue_we;
  logic [IdxW-1:0] queue_rdata;

  logic            accept;
  logic            finish;

  // Allocation decision
  logic [CntW-1:0] room;
  logic [CntW-1:0] bpp_ext;
  logic [CntW-1:0] add;
  logic            exhausted;
  logic            grow;
  logic            have_fresh;
  logic            have_queued;
  logic            alloc_ok;
  logic            idx_invalid;
  logic            idx_in_use;
  logic            free_ok;

  assign accept = in_valid_i && in_ready_o;
  assign finish = (state_q == SExec) && (!out_valid_q || out_ready_i);

  assign in_ready_o = (state_q == SIdle);

  // Free-list FIFO storage.
  bpa_ram #(
    .WIDTH (IdxW),
    .DEPTH (MaxBlocks)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (queue_we),
    .waddr_i (tail_q),
    .wdata_i (idx_q),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (queue_rdata)
  );

  // In-use flag per block.
  bpa_ram #(
    .WIDTH (1),
    .DEPTH (MaxBlocks)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (flag_we),
    .waddr_i (flag_waddr),
    .wdata_i (flag_wdata),
    .re_i    (accept),
    .raddr_i (block_index_i),
    .rdata_o (flag_rdata)
  );

  // Growth: clip the new pool to the room left in the index space.
  assign room      = CntW'(MaxBlocks) - fresh_limit_q;
  assign bpp_ext   = CntW'(bpp_q);
  assign add       = (bpp_ext < room) ? bpp_ext : room;
  assign exhausted = (fresh_next_q >= fresh_limit_q) && (count_q == '0);
  assign grow      = exhausted && (pools_q < PoolW'(MAX_POOLS)) && (add != '0);

  assign have_fresh  = fresh_next_q < fresh_limit_q;
  assign have_queued = count_q != '0;
  assign alloc_ok    = grow || have_fresh || have_queued;

  // Free checks. Flags of indices at or past the fresh pointer were never
  // written and read as free.
  assign idx_invalid = CntW'(idx_q) >= fresh_limit_q;
  assign idx_in_use  = flag_rdata && (CntW'(idx_q) < fresh_next_q);
  assign free_ok     = !idx_invalid && idx_in_use;

  always_comb begin
    state_d       = state_q;
    bpp_d         = bpp_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    pools_d       = pools_q;
    fresh_next_d  = fresh_next_q;
    fresh_limit_d = fresh_limit_q;
    out_valid_d   = out_valid_q;
    granted_d     = granted_q;
    status_d      = status_q;
    flag_we       = 1'b0;
    flag_waddr    = idx_q;
    flag_wdata    = 1'b0;
    queue_we      = 1'b0;

    // Drop the response once it is taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      SIdle: begin
        if (accept) begin
          state_d = SExec;
        end
      end
      SExec: begin
        if (finish) begin
          state_d     = SIdle;
          out_valid_d = 1'b1;
          granted_d   = '0;
          status_d    = ST_OK;
          if (cmd_q == CmdAlloc) begin
            if (grow) begin
              granted_d     = fresh_limit_q[IdxW-1:0];
              pools_d       = pools_q + PoolW'(1);
              fresh_next_d  = fresh_limit_q + CntW'(1);
              fresh_limit_d = fresh_limit_q + add;
            end else if (have_fresh) begin
              granted_d    = fresh_next_q[IdxW-1:0];
              fresh_next_d = fresh_next_q + CntW'(1);
            end else if (have_queued) begin
              granted_d = queue_rdata;
              head_d    = head_q + IdxW'(1);
              count_d   = count_q - CntW'(1);
            end else begin
              status_d = ST_OOM;
            end
            // Mark the granted block as in use.
            flag_we    = alloc_ok;
            flag_waddr = granted_d;
            flag_wdata = 1'b1;
          end else begin
            if (idx_invalid) begin
              status_d = ST_INVALID;
            end else if (!idx_in_use) begin
              status_d = ST_DOUBLE;
            end else begin
              // Clear the flag and append the block to the free list.
              flag_we  = 1'b1;
              queue_we = 1'b1;
              tail_d   = tail_q + IdxW'(1);
              count_d  = count_q + CntW'(1);
            end
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase

    // The user must write configuration only while idle; the block does not enforce it.
    if (cfg_we_i) begin
      bpp_d = cfg_wdata_i;
      if ((pools_q == PoolW'(1)) && (fresh_next_q == '0) && (count_q == '0)) begin
        fresh_limit_d = CntW'(cfg_wdata_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SIdle;
      bpp_q         <= BppReset;
      head_q        <= '0;
      tail_q        <= '0;
      count_q       <= '0;
      pools_q       <= PoolW'(1);
      fresh_next_q  <= '0;
      fresh_limit_q <= CntW'(BppReset);
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      bpp_q         <= bpp_d;
      head_q        <= head_d;
      tail_q        <= tail_d;
      count_q       <= count_d;
      pools_q       <= pools_d;
      fresh_next_q  <= fresh_next_d;
      fresh_limit_q <= fresh_limit_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers: capture the request, hold the response.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= command_i;
      idx_q <= block_index_i;
    end
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign granted_index_o = granted_q;
  assign status_o        = status_q;

  // Assertions
  `ASSERT_AT(a_fresh_order, fresh_next_q <= fresh_limit_q, "fresh pointer past pool limit")
  `ASSERT_AT(a_pool_range, (pools_q != '0) && (pools_q <= PoolW'(MAX_POOLS)), "pool count out of range")
  `ASSERT_AT(a_load_from_exec, $rose(out_valid_q) |-> $past(state_q == SExec), "response loaded outside execute")
  `ASSERT_NEVER(a_ok_grant_range, out_valid_q && (status_q == ST_OK) && (CntW'(granted_q) >= fresh_limit_q), "granted index beyond pools")
  `ASSERT_AT(a_count_bound, (count_q <= fresh_limit_q) && (count_q <= CntW'(MaxBlocks)), "free list larger than pool")

endmodule

`default_nettype wire

FILE: sim/tb_block_pool_allocator.sv
// Self-checking testbench for block_pool_allocator: directed and random
// allocate/free traffic against an in-bench prediction of the pool state.
// Depends on bpa_pkg and the block_pool_allocator RTL.
`timescale 1ns / 100ps

module tb_block_pool_allocator;
  import bpa_pkg::*;

  localparam int unsigned PoolLimit = 16;

  // One response as the block should present it.
  typedef struct packed {
    logic [IdxW-1:0] index;
    status_e         status;
  } grant_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [BppW-1:0]   cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              command_i;
  logic [IdxW-1:0]   block_index_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [IdxW-1:0]   granted_index_o;
  logic [1:0]        status_o;

  block_pool_allocator #(
    .MAX_POOLS(PoolLimit)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .block_index_i  (block_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .granted_index_o(granted_index_o),
    .status_o       (status_o)
  );

  // 8 ns period.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predicted allocator state, updated at every accepted request transfer.
  // ---------------------------------------------------------------------------
  int unsigned     pool_size      = 32'(BppReset);   // blocks added per growth
  int unsigned     blocks_present = 32'(BppReset);   // first pool at reset size
  int unsigned     pool_count     = 1;
  int unsigned     next_fresh     = 0;          // next fresh block of newest pool
  logic [IdxW-1:0] freed_fifo [MaxBlocks];      // freed blocks, oldest first
  int unsigned     fifo_rd        = 0;
  int unsigned     fifo_wr        = 0;
  int unsigned     fifo_fill      = 0;
  bit              block_taken [MaxBlocks];

  // Blocks handed out and not yet freed; stimulus frees from here.
  logic [IdxW-1:0] held_blocks [$];
  grant_t          expected_grants [$];
  status_e         last_status;

  // Run bookkeeping.
  int unsigned fail_count = 0;
  int unsigned responses_checked = 0;
  int unsigned alloc_count = 0;
  int unsigned free_count = 0;
  int unsigned status_tally [4];

  // Traffic shaping shared by the sender and the response sink.
  bit          idling_on = 1'b1;
  int unsigned sink_hold_cycles = 0;

  function automatic int unsigned clip_to_index_space(int unsigned base, int unsigned size);
    int unsigned room;
    room = (base < MaxBlocks) ? MaxBlocks - base : 0;
    return (size < room) ? size : room;
  endfunction

  // Apply one request to the predicted state and return the response it earns.
  function automatic grant_t predict_request(logic cmd, logic [IdxW-1:0] idx);
    grant_t      g;
    int unsigned add;
    int          hits [$];
    g.index  = '0;
    g.status = ST_OK;
    if (cmd == CmdAlloc) begin
      alloc_count++;
      // Grow only when both fresh blocks and the freed queue are used up.
      if (next_fresh >= blocks_present && fifo_fill == 0) begin
        add = clip_to_index_space(blocks_present, pool_size);
        if (pool_count < PoolLimit && add != 0) begin
          pool_count++;
          next_fresh     = blocks_present;
          blocks_present += add;
        end
      end
      // Fresh blocks take priority over the freed queue.
      if (next_fresh < blocks_present) begin
        g.index = next_fresh[IdxW-1:0];
        next_fresh++;
      end else if (fifo_fill != 0) begin
        g.index = freed_fifo[fifo_rd];
        fifo_rd = (fifo_rd + 1) % MaxBlocks;
        fifo_fill--;
      end else begin
        g.status = ST_OOM;
      end
      if (g.status == ST_OK) begin
        block_taken[g.index] = 1'b1;
        held_blocks.push_back(g.index);
      end
    end else begin
      free_count++;
      if (idx >= blocks_present) begin
        g.status = ST_INVALID;
      end else if (!block_taken[idx]) begin
        g.status = ST_DOUBLE;
      end else begin
        block_taken[idx]    = 1'b0;
        freed_fifo[fifo_wr] = idx;
        fifo_wr = (fifo_wr + 1) % MaxBlocks;
        fifo_fill++;
        hits = held_blocks.find_first_index(b) with (b == idx);
        if (hits.size() != 0) held_blocks.delete(hits[0]);
      end
    end
    status_tally[g.status]++;
    last_status = g.status;
    return g;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idling_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [IdxW-1:0] pick_held_block();
    return held_blocks[$urandom_range(0, held_blocks.size() - 1)];
  endfunction

  function automatic logic [IdxW-1:0] pick_any_index();
    return IdxW'($urandom_range(0, MaxBlocks - 1));
  endfunction

  // ---------------------------------------------------------------------------
  // Request side. Every task starts and ends at a falling edge. send_request
  // leaves valid high so that back-to-back items never lower and raise it in
  // the same step; whoever stops sending drops valid.
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic cmd, input logic [IdxW-1:0] idx);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    block_index_i <= idx;
    // Hold the payload until the transfer happens.
    do @(posedge clk_i); while (!in_ready_o);
    expected_grants.push_back(predict_request(cmd, idx));
    @(negedge clk_i);
  endtask

  // Drop valid and hold off until every predicted response has been checked.
  task automatic wait_for_responses();
    in_valid_i <= 1'b0;
    while (expected_grants.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Write blocks_per_pool with the block idle. While nothing has been handed
  // out yet, the write also resizes the first pool.
  task automatic write_pool_size(input logic [BppW-1:0] size);
    wait_for_responses();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    pool_size = 32'(size);
    if (pool_count == 1 && next_fresh == 0 && fifo_fill == 0)
      blocks_present = clip_to_index_space(0, 32'(size));
  endtask

  // Random mix: allocates, frees of held blocks, and bad frees as noise.
  task automatic run_mixed_requests(input int unsigned count, input int unsigned alloc_pct);
    int unsigned     r;
    logic [IdxW-1:0] idx;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < alloc_pct) begin
        // Index is ignored on allocate; randomize it anyway.
        send_request(CmdAlloc, pick_any_index());
      end else if (r < alloc_pct + 33 && held_blocks.size() != 0) begin
        send_request(CmdFree, pick_held_block());
      end else begin
        case ($urandom_range(0, 3))
          0: idx = pick_any_index();
          1: idx = (blocks_present == 0) ? '0 :
                   IdxW'($urandom_range(0, blocks_present - 1));
          2: idx = (blocks_present >= MaxBlocks) ? '1 : blocks_present[IdxW-1:0];
          default: idx = '1;
        endcase
        send_request(CmdFree, idx);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests, run in order on one reset; each one builds on the state left over.
  // ---------------------------------------------------------------------------

  // Empty first pool: allocate finds nothing and cannot grow; every free is out
  // of range.
  task automatic test_zero_pool_size();
    write_pool_size('0);
    send_request(CmdAlloc, '1);
    send_request(CmdFree, '0);
    send_request(CmdFree, '1);
  endtask

  // Resize the first pool to two blocks, then walk serving order, double and
  // invalid frees, growth, and a size write that must not touch existing pools.
  task automatic test_first_pool_and_serving_order();
    write_pool_size(7'd2);
    send_request(CmdAlloc, '0);   // fresh 0
    send_request(CmdAlloc, '1);   // fresh 1
    send_request(CmdFree, 10'd1);
    send_request(CmdFree, 10'd1); // already free
    send_request(CmdFree, 10'd2); // beyond the blocks present
    send_request(CmdAlloc, '0);   // freed queue
    send_request(CmdAlloc, '0);   // grows a second pool
    write_pool_size(7'd1);        // later growth only
    send_request(CmdFree, 10'd3); // present but never handed out
    send_request(CmdAlloc, '0);
    send_request(CmdFree, 10'd0);
    send_request(CmdFree, 10'd3);
    send_request(CmdAlloc, '1);   // oldest freed first
    send_request(CmdAlloc, '1);
    send_request(CmdAlloc, '0);   // one-block pool
    send_request(CmdAlloc, '0);   // another one-block pool
    send_request(CmdFree, 10'd5);
    send_request(CmdAlloc, '0);
  endtask

  // Random traffic over several small pool sizes, the one-block pool among
  // them. One setting runs with no idling on either side.
  task automatic test_mixed_traffic();
    write_pool_size(7'd4);
    run_mixed_requests(50, 55);
    write_pool_size(7'd1);
    idling_on = 1'b0;
    run_mixed_requests(50, 55);
    idling_on = 1'b1;
    write_pool_size(7'd16);
    run_mixed_requests(50, 55);
    write_pool_size(BppW'($urandom_range(1, 16)));
    run_mixed_requests(50, 55);
  endtask

  // Allocate until out of memory: growth runs into the pool limit.
  task automatic test_pool_exhaustion();
    int unsigned guard;
    write_pool_size(7'd6);
    guard = 0;
    do begin
      send_request(CmdAlloc, pick_any_index());
      guard++;
    end while (last_status != ST_OOM && guard < 1200);
    repeat (3) send_request(CmdAlloc, pick_any_index());
    run_mixed_requests(30, 50);
  endtask

  // Stall the response side for a long stretch while requests keep coming, so
  // the block fills up and stops taking input; then pause until all is back.
  task automatic test_backpressure();
    sink_hold_cycles = 200;
    repeat (30) begin
      if (held_blocks.size() != 0) send_request(CmdFree, pick_held_block());
      else send_request(CmdFree, pick_any_index());
    end
    wait_for_responses();
    repeat (30) send_request(CmdAlloc, pick_any_index());
  endtask

  // Free every held block back to back, then take them all back in the order
  // they were freed until nothing is left.
  task automatic test_queue_wrap();
    int unsigned guard;
    idling_on = 1'b0;
    while (held_blocks.size() != 0) send_request(CmdFree, pick_held_block());
    idling_on = 1'b1;
    guard = 0;
    do begin
      send_request(CmdAlloc, pick_any_index());
      guard++;
    end while (last_status != ST_OOM && guard < 1200);
    run_mixed_requests(40, 45);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: random ready with stalls, plus a long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : response_sink
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold_cycles != 0) begin
        out_ready_i <= 1'b0;
        sink_hold_cycles--;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Compare every response transfer with the oldest prediction.
  always @(posedge clk_i) begin : response_check
    grant_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_grants.size() == 0) begin
        $display("%0t: unexpected response, granted_index %0d status %0d",
                 $time, granted_index_o, status_o);
        fail_count++;
      end else begin
        want = expected_grants.pop_front();
        responses_checked++;
        if (granted_index_o !== want.index) begin
          $display("%0t: granted_index expected %0d, actual %0d",
                   $time, want.index, granted_index_o);
          fail_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %s, actual %0d",
                   $time, want.status.name(), status_o);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset once, run the tests, drain, report.
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    int unsigned w;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    command_i     = CmdAlloc;
    block_index_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_zero_pool_size();
    test_first_pool_and_serving_order();
    test_mixed_traffic();
    test_pool_exhaustion();
    test_backpressure();
    test_queue_wrap();

    // Drop valid and give outstanding responses a bounded time to arrive.
    in_valid_i <= 1'b0;
    for (w = 0; w < 4000 && expected_grants.size() != 0; w++) @(posedge clk_i);
    if (expected_grants.size() != 0) begin
      $display("%0t: %0d expected responses never arrived", $time, expected_grants.size());
      fail_count += expected_grants.size();
    end
    // Catch any stray response after the last one.
    repeat (8) @(posedge clk_i);

    $display("Covered %0d requests (%0d allocate, %0d free), %0d responses checked.",
             alloc_count + free_count, alloc_count, free_count, responses_checked);
    $display("Statuses: %0d ok, %0d oom, %0d double, %0d invalid; %0d pools, %0d blocks.",
             status_tally[ST_OK], status_tally[ST_OOM], status_tally[ST_DOUBLE],
             status_tally[ST_INVALID], pool_count, blocks_present);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Generous upper bound on the whole run.
  initial begin : watchdog
    #10_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: block_pool_allocator.f
+incdir+src
src/bpa_pkg.sv
src/bpa_ram.sv
src/block_pool_allocator.sv
sim/tb_block_pool_allocator.sv
